// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the best-route selection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BRS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("brs assertion failed");
`define BRS_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("brs forbidden condition seen");
`else
`define BRS_ASSERT(lbl, prop)
`define BRS_NEVER(lbl, expr)
`endif
`endif

// ----- rtl/brs_pkg.sv -----
// Shared types and widths for the best-route selection block.
package brs_pkg;

  localparam int KEY_W  = 16;
  localparam int AREA_W = 4;
  localparam int VAL_W  = 32;

  typedef struct packed {
    logic [KEY_W-1:0]         key;
    logic [AREA_W-1:0]        area;
    logic                     drained;
    logic signed [VAL_W-1:0]  path;
    logic signed [VAL_W-1:0]  src;
    logic signed [VAL_W-1:0]  route_dist;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic drop;
    logic rd_en;
    logic upd;
    logic set_pend;
    logic push_pend;
    logic push_final;
    logic clear_run;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic survivor;
    logic pend_valid;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/brs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module brs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/brs_ctrl.sv -----
// Controller: load counter, store walks and result sequencing.
`include "assert_macros.svh"

module brs_ctrl #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          in_valid_i,
  input  logic                                          in_last_i,
  output logic                                          in_ready_o,
  input  brs_pkg::dp_status_t                           status_i,
  output brs_pkg::dp_cmd_t                              cmd_o,
  output logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] waddr_o,
  output logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] raddr_o
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_W1     = 3'd1;
  localparam logic [2:0] ST_W1_END = 3'd2;
  localparam logic [2:0] ST_W2_RD  = 3'd3;
  localparam logic [2:0] ST_W2_CHK = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] count_m1;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] last_idx;
  logic          upd_q, upd_d;
  logic          has_room;
  logic          idx_at_last;
  logic          advance;

  assign count_m1    = count_q - 1'b1;
  assign last_idx    = IW'(count_m1);
  assign idx_at_last = (idx_q == last_idx);
  assign has_room    = (count_q < CW'(MAX_ENTRIES));
  assign waddr_o     = IW'(count_q);
  assign raddr_o     = idx_q;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    upd_d      = 1'b0;
    advance    = 1'b0;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.upd  = upd_q;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (has_room) begin
            cmd_o.load = 1'b1;
            count_d    = count_q + 1'b1;
          end else begin
            cmd_o.drop = 1'b1;
          end
          if (in_last_i) begin
            idx_d   = '0;
            state_d = ST_W1;
          end
        end
      end
      ST_W1: begin
        // rank walk: read one entry a cycle, data is used in the next cycle
        cmd_o.rd_en = 1'b1;
        upd_d       = 1'b1;
        if (idx_at_last) begin
          state_d = ST_W1_END;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_W1_END: begin
        idx_d   = '0;
        state_d = ST_W2_RD;
      end
      ST_W2_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_W2_CHK;
      end
      ST_W2_CHK: begin
        // hold one survivor back so the last one can carry out_last
        if (status_i.survivor) begin
          if (status_i.pend_valid) begin
            if (status_i.out_free) begin
              cmd_o.push_pend = 1'b1;
              cmd_o.set_pend  = 1'b1;
              advance         = 1'b1;
            end
          end else begin
            cmd_o.set_pend = 1'b1;
            advance        = 1'b1;
          end
        end else begin
          advance = 1'b1;
        end
        if (advance) begin
          if (idx_at_last) begin
            state_d = ST_FIN;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_W2_RD;
          end
        end
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.push_final = 1'b1;
          cmd_o.clear_run  = 1'b1;
          count_d          = '0;
          state_d          = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      idx_q   <= '0;
      upd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      upd_q   <= upd_d;
    end
  end

  `BRS_ASSERT(a_count_bound, count_q <= CW'(MAX_ENTRIES))
  `BRS_ASSERT(a_fin_returns, cmd_o.push_final |=> (state_q == ST_LOAD && count_q == '0))
  `BRS_ASSERT(a_chk_after_read, (state_q == ST_W2_CHK) |-> ($past(state_q) == ST_W2_RD || $past(state_q) == ST_W2_CHK))

endmodule

// ----- rtl/brs_dp.sv -----
// Datapath: best tuple, distance minima, pending survivor and output word.
`include "assert_macros.svh"

module brs_dp #(
  parameter int NUM_AREAS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [1:0]                        cfg_data_i,
  input  logic [brs_pkg::KEY_W-1:0]         in_key_i,
  input  logic [brs_pkg::AREA_W-1:0]        in_area_i,
  input  logic signed [brs_pkg::VAL_W-1:0]  in_drain_i,
  input  logic                              in_node_drained_i,
  input  logic signed [brs_pkg::VAL_W-1:0]  in_path_i,
  input  logic signed [brs_pkg::VAL_W-1:0]  in_src_i,
  input  logic signed [brs_pkg::VAL_W-1:0]  in_dist_i,
  input  brs_pkg::dp_cmd_t                  cmd_i,
  output brs_pkg::dp_status_t               status_o,
  output brs_pkg::entry_t                   wdata_o,
  input  brs_pkg::entry_t                   rdata_i,
  input  logic                              m_ready_i,
  output logic                              out_valid_o,
  output logic [brs_pkg::KEY_W-1:0]         out_key_o,
  output logic                              out_none_o,
  output logic                              out_ovf_o,
  output logic                              out_last_o
);

  localparam int AREA_SPAN  = 2 ** brs_pkg::AREA_W;
  localparam int AREA_SLOTS = (NUM_AREAS < AREA_SPAN) ? NUM_AREAS : AREA_SPAN;
  localparam int ASW        = (AREA_SLOTS > 1) ? $clog2(AREA_SLOTS) : 1;

  localparam logic [1:0] MODE_GLOBAL = 2'd0;
  localparam logic [1:0] MODE_AREA   = 2'd1;

  localparam logic signed [brs_pkg::VAL_W-1:0] DIST_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [brs_pkg::VAL_W-1:0] PREF_MIN = 32'sh8000_0000;

  // area number folded onto the area slots
  function automatic logic [AREA_SPAN-1:0][ASW-1:0] build_fold();
    logic [AREA_SPAN-1:0][ASW-1:0] t;
    for (int i = 0; i < AREA_SPAN; i++) begin
      t[i] = ASW'(i % NUM_AREAS);
    end
    return t;
  endfunction

  localparam logic [AREA_SPAN-1:0][ASW-1:0] FOLD = build_fold();

  function automatic logic tuple_better(
    input logic                             a_dr,
    input logic signed [brs_pkg::VAL_W-1:0] a_pp,
    input logic signed [brs_pkg::VAL_W-1:0] a_sp,
    input logic                             b_dr,
    input logic signed [brs_pkg::VAL_W-1:0] b_pp,
    input logic signed [brs_pkg::VAL_W-1:0] b_sp
  );
    logic r;
    if (a_dr != b_dr) begin
      r = !a_dr;
    end else if (a_pp != b_pp) begin
      r = (a_pp > b_pp);
    end else begin
      r = (a_sp > b_sp);
    end
    return r;
  endfunction

  logic [1:0]                        mode_q;
  logic                              best_dr_q;
  logic signed [brs_pkg::VAL_W-1:0]  best_pp_q, best_sp_q;
  logic                              seen_q;
  logic                              ovf_q;
  logic signed [brs_pkg::VAL_W-1:0]  gmin_q;
  logic [AREA_SLOTS-1:0]             avalid_q;
  logic signed [brs_pkg::VAL_W-1:0]  amin_q [AREA_SLOTS];
  logic                              pend_valid_q;
  logic [brs_pkg::KEY_W-1:0]         pend_key_q;
  logic                              out_valid_q;
  logic [brs_pkg::KEY_W-1:0]         out_key_q;
  logic                              out_none_q, out_ovf_q, out_last_q;

  logic                              in_drained;
  logic                              in_better;
  logic signed [brs_pkg::VAL_W-1:0]  rd_path, rd_src, rd_dist;
  logic                              mode_ok;
  logic                              keep;
  logic [ASW-1:0]                    rd_slot;
  logic signed [brs_pkg::VAL_W-1:0]  slot_min;
  logic                              survivor;
  logic                              out_free;

  assign in_drained = (in_drain_i != '0) || in_node_drained_i;
  assign in_better  = tuple_better(in_drained, in_path_i, in_src_i,
                                   best_dr_q, best_pp_q, best_sp_q);

  always_comb begin
    wdata_o            = '0;
    wdata_o.key        = in_key_i;
    wdata_o.area       = in_area_i;
    wdata_o.drained    = in_drained;
    wdata_o.path       = in_path_i;
    wdata_o.src        = in_src_i;
    wdata_o.route_dist = in_dist_i;
  end

  assign rd_path  = rdata_i.path;
  assign rd_src   = rdata_i.src;
  assign rd_dist  = rdata_i.route_dist;
  assign mode_ok  = (mode_q == MODE_GLOBAL) || (mode_q == MODE_AREA);
  assign keep     = mode_ok && seen_q && (rdata_i.drained == best_dr_q) &&
                    (rd_path == best_pp_q) && (rd_src == best_sp_q);
  assign rd_slot  = FOLD[rdata_i.area];
  assign slot_min = avalid_q[rd_slot] ? amin_q[rd_slot] : DIST_MAX;
  assign survivor = keep && ((mode_q == MODE_GLOBAL) ? (rd_dist == gmin_q)
                                                     : (rd_dist == slot_min));
  assign out_free = !out_valid_q || m_ready_i;

  assign status_o.survivor   = survivor;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_GLOBAL;
      best_dr_q    <= 1'b1;
      best_pp_q    <= PREF_MIN;
      best_sp_q    <= PREF_MIN;
      seen_q       <= 1'b0;
      ovf_q        <= 1'b0;
      gmin_q       <= DIST_MAX;
      avalid_q     <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        seen_q <= 1'b1;
        if (in_better) begin
          best_dr_q <= in_drained;
          best_pp_q <= in_path_i;
          best_sp_q <= in_src_i;
        end
      end
      if (cmd_i.drop) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.upd && keep) begin
        if (rd_dist < gmin_q) begin
          gmin_q <= rd_dist;
        end
        if (rd_dist < slot_min) begin
          avalid_q[rd_slot] <= 1'b1;
        end
      end
      if (cmd_i.set_pend) begin
        pend_valid_q <= 1'b1;
      end
      if (cmd_i.push_pend || cmd_i.push_final) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // return run state to its reset values
      if (cmd_i.clear_run) begin
        best_dr_q    <= 1'b1;
        best_pp_q    <= PREF_MIN;
        best_sp_q    <= PREF_MIN;
        seen_q       <= 1'b0;
        ovf_q        <= 1'b0;
        gmin_q       <= DIST_MAX;
        avalid_q     <= '0;
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd && keep && (rd_dist < slot_min)) begin
      amin_q[rd_slot] <= rd_dist;
    end
    if (cmd_i.set_pend) begin
      pend_key_q <= rdata_i.key;
    end
    if (cmd_i.push_pend) begin
      out_key_q  <= pend_key_q;
      out_none_q <= 1'b0;
      out_ovf_q  <= ovf_q;
      out_last_q <= 1'b0;
    end else if (cmd_i.push_final) begin
      out_key_q  <= pend_valid_q ? pend_key_q : '0;
      out_none_q <= !pend_valid_q;
      out_ovf_q  <= ovf_q;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_key_o   = out_key_q;
  assign out_none_o  = out_none_q;
  assign out_ovf_o   = out_ovf_q;
  assign out_last_o  = out_last_q;

  `BRS_ASSERT(a_push_needs_room, (cmd_i.push_pend || cmd_i.push_final) |-> (!out_valid_q || m_ready_i))
  `BRS_ASSERT(a_pend_not_lost, (cmd_i.set_pend && pend_valid_q) |-> cmd_i.push_pend)

endmodule

// ----- rtl/best_route_select.sv -----
// Top level of the best-route selection block.
// Candidates stream in one word a cycle while loading and go into a
// MAX_ENTRIES-deep store while the best (not drained, path preference, source
// preference) tuple is tracked; words past capacity are dropped and flagged.
// The word with tlast starts selection: a rank walk reads the store at one
// entry a cycle to find the shortest distance, globally or per area, then an
// emit walk reads and checks each entry through the store's single read port,
// waiting on any output stall, and a closing state sends the word with tlast.
// New candidates are taken again once that word is in the output register.
module best_route_select #(
  parameter int MAX_ENTRIES = 64,
  parameter int NUM_AREAS   = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: entry_key[15:0], area_id[19:16], drain_value[51:20],
  //        node_drained[52], path_pref[84:53], source_pref[116:85],
  //        route_distance[148:117], zero[151:149]
  input  logic [151:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: chosen_key[15:0], capacity_exceeded[16], zero[23:17]
  output logic [23:0]  m_axis_tdata,
  // tuser: none_chosen[0]
  output logic         m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_data_i
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  brs_pkg::dp_cmd_t    cmd;
  brs_pkg::dp_status_t status;
  brs_pkg::entry_t     wdata, rdata;
  logic [IW-1:0]       waddr, raddr;
  logic [brs_pkg::KEY_W-1:0] out_key;
  logic                out_none, out_ovf, out_last, out_valid;

  assign cfg_ready_o = 1'b1;

  brs_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd),
    .waddr_o    (waddr),
    .raddr_o    (raddr)
  );

  brs_ram #(
    .WIDTH ($bits(brs_pkg::entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd.load),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  brs_dp #(
    .NUM_AREAS (NUM_AREAS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .in_key_i          (s_axis_tdata[15:0]),
    .in_area_i         (s_axis_tdata[19:16]),
    .in_drain_i        (s_axis_tdata[51:20]),
    .in_node_drained_i (s_axis_tdata[52]),
    .in_path_i         (s_axis_tdata[84:53]),
    .in_src_i          (s_axis_tdata[116:85]),
    .in_dist_i         (s_axis_tdata[148:117]),
    .cmd_i             (cmd),
    .status_o          (status),
    .wdata_o           (wdata),
    .rdata_i           (rdata),
    .m_ready_i         (m_axis_tready),
    .out_valid_o       (out_valid),
    .out_key_o         (out_key),
    .out_none_o        (out_none),
    .out_ovf_o         (out_ovf),
    .out_last_o        (out_last)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_ovf, out_key};
  assign m_axis_tuser  = out_none;
  assign m_axis_tlast  = out_last;

endmodule
